// File: design/dimmer_channel_setpoint_control_assert.svh
// ----------------------------------------------------------------------------
// Dimmer channel setpoint control - assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DIMMER_CHANNEL_SETPOINT_CONTROL_ASSERT_SVH
`define DIMMER_CHANNEL_SETPOINT_CONTROL_ASSERT_SVH

// assertion that is off while reset is asserted
`define DCSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that is also checked during reset
`define DCSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dcsc_pkg.sv
// ----------------------------------------------------------------------------
// Dimmer channel setpoint control - package
// Types, command codes, register indexes and helpers of the channel.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [6:0] LevelMax          = 7'd100;
  localparam logic [6:0] MemoryMin         = 7'd5;
  localparam logic [7:0] RecallMark        = 8'd255;
  localparam logic [6:0] InitialLastReset  = 7'd100;

  typedef enum logic [3:0] {
    FUNC_QUERY         = 4'd0,
    FUNC_TOGGLE        = 4'd1,
    FUNC_SET_FADE      = 4'd2,
    FUNC_SET           = 4'd3,
    FUNC_GOTO_LAST     = 4'd4,
    FUNC_GOTO_DEFAULT  = 4'd5,
    FUNC_STOP          = 4'd6,
    FUNC_POST_CURRENT  = 4'd7,
    FUNC_CLEAR_CHANGED = 4'd8,
    FUNC_MARK_SENT     = 4'd9,
    FUNC_INIT          = 4'd10
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_LEVEL  = 2'd0,
    CFG_DEFAULT_FADE = 2'd1,
    CFG_INITIAL_LAST = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] level;
    logic [7:0] low_level;
    logic [7:0] fade_rate;
  } cmd_t;

  typedef struct packed {
    logic       unchanged;
    logic [6:0] setpoint_out;
    logic [7:0] fade_out;
    logic [7:0] current_out;
    logic       rising;
    logic       changed_flag;
    logic       sent_flag;
    logic       is_on;
    logic       is_changing;
    logic [6:0] remembered_level;
  } result_t;

  typedef struct packed {
    logic [6:0] target_level;
    logic [6:0] memory_level;
    logic [7:0] actual_level;
    logic [7:0] active_fade;
    logic       direction_up;
    logic       sp_changed_bit;
    logic       status_sent_bit;
  } chan_state_t;

  typedef struct packed {
    logic [6:0] start_level;
    logic [7:0] default_fade_rate;
    logic [6:0] initial_last_level;
  } cfg_t;

  function automatic logic [6:0] clamp_hi(logic [7:0] v);
    return (v > {1'b0, LevelMax}) ? LevelMax : v[6:0];
  endfunction

endpackage

`default_nettype wire

// File: design/dcsc_cmd.sv
// ----------------------------------------------------------------------------
// Dimmer channel setpoint control - command logic
// Next channel state and status item for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsc_cmd (
  input  dcsc_pkg::cmd_t      cmd_i,
  input  dcsc_pkg::chan_state_t state_i,
  input  dcsc_pkg::cfg_t      cfg_i,
  output dcsc_pkg::chan_state_t state_o,
  output dcsc_pkg::result_t   result_o
);
  import dcsc_pkg::*;

  logic        apply_en;
  logic        load_fade;
  logic [7:0]  apply_lvl;
  logic [7:0]  apply_fade;
  logic [6:0]  want;
  logic        same;
  logic        unchanged;
  logic        stop_active;
  logic [6:0]  stop_mem;
  chan_state_t st;

  assign stop_active = (state_i.actual_level != {1'b0, state_i.target_level});
  assign stop_mem    = (clamp_hi(state_i.actual_level) < MemoryMin) ? MemoryMin :
                       clamp_hi(state_i.actual_level);

  // level source for the shared apply path
  always_comb begin
    apply_en   = 1'b0;
    load_fade  = 1'b0;
    apply_lvl  = cmd_i.level;
    apply_fade = cmd_i.fade_rate;
    case (cmd_i.func)
      FUNC_TOGGLE: begin
        apply_en  = 1'b1;
        load_fade = 1'b1;
        if (cmd_i.level == RecallMark) begin
          apply_lvl = (state_i.target_level != '0) ? cmd_i.low_level :
                      {1'b0, clamp_hi({1'b0, state_i.memory_level})};
        end else begin
          apply_lvl = state_i.direction_up ? cmd_i.low_level : cmd_i.level;
        end
      end
      FUNC_SET_FADE: begin
        apply_en  = 1'b1;
        load_fade = 1'b1;
      end
      FUNC_SET: begin
        apply_en = 1'b1;
      end
      FUNC_GOTO_LAST: begin
        apply_en  = 1'b1;
        apply_lvl = {1'b0, state_i.memory_level};
      end
      FUNC_GOTO_DEFAULT: begin
        apply_en  = 1'b1;
        apply_lvl = {1'b0, cfg_i.start_level};
      end
      FUNC_STOP: begin
        apply_en   = stop_active;
        load_fade  = 1'b1;
        apply_lvl  = state_i.actual_level;
        apply_fade = cfg_i.default_fade_rate;
      end
      default: begin
      end
    endcase
  end

  assign want = clamp_hi(apply_lvl);
  assign same = (want == state_i.target_level);

  always_comb begin
    st        = state_i;
    unchanged = 1'b0;
    if (apply_en && !same) begin
      st.direction_up    = (want > state_i.target_level);
      st.target_level    = want;
      st.status_sent_bit = 1'b0;
      st.sp_changed_bit  = 1'b1;
      if (load_fade) begin
        st.active_fade = apply_fade;
      end
    end
    case (cmd_i.func)
      FUNC_SET_FADE, FUNC_SET: begin
        unchanged = same;
      end
      FUNC_STOP: begin
        if (stop_active) begin
          st.memory_level = stop_mem;
          st.direction_up = (state_i.actual_level < {1'b0, state_i.target_level});
        end
      end
      FUNC_POST_CURRENT: begin
        st.actual_level = cmd_i.level;
      end
      FUNC_CLEAR_CHANGED: begin
        st.sp_changed_bit = 1'b0;
      end
      FUNC_MARK_SENT: begin
        st.status_sent_bit = 1'b1;
      end
      FUNC_INIT: begin
        st.target_level    = clamp_hi({1'b0, cfg_i.start_level});
        st.memory_level    = clamp_hi({1'b0, cfg_i.initial_last_level});
        st.actual_level    = '0;
        st.direction_up    = (clamp_hi({1'b0, cfg_i.start_level}) != '0);
        st.sp_changed_bit  = 1'b1;
        st.status_sent_bit = 1'b0;
        st.active_fade     = cfg_i.default_fade_rate;
      end
      default: begin
      end
    endcase
  end

  assign state_o = st;

  always_comb begin
    result_o.unchanged        = unchanged;
    result_o.setpoint_out     = st.target_level;
    result_o.fade_out         = st.active_fade;
    result_o.current_out      = st.actual_level;
    result_o.rising           = st.direction_up;
    result_o.changed_flag     = st.sp_changed_bit;
    result_o.sent_flag        = st.status_sent_bit;
    result_o.is_on            = (st.actual_level != '0);
    result_o.is_changing      = (st.actual_level != {1'b0, st.target_level});
    result_o.remembered_level = st.memory_level;
  end

endmodule

`default_nettype wire

// File: design/dimmer_channel_setpoint_control.sv
// ----------------------------------------------------------------------------
// Dimmer channel setpoint control - top level
// Command handler for one dimmer channel, one status item per command.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_* valid/ready channel, one transfer per command.
//   Every command yields exactly one status transfer on the out_* channel.
//   The user writes cfg_* port registers (enable, index, data) while the
//   channel is idle, unchecked here; init, goto default and stop read them.
//   An accepted command is held in the input register; its status is
//   registered in the output register when it advances, visible from then on.
//   Throughput: one command per cycle unless out_ready_i stalls; the channel
//   state and status are registered together, so the next command sees it.
//   Stall: when out_ready_i is low, the output register holds; one more
//   command waits in the input register, then in_ready_o drops.
//   Reset: rst_ni clears the channel state to zero, both stages to empty,
//   and the registers to start level 0, fade 0, remembered level 100.
// ----------------------------------------------------------------------------
`default_nettype none

module dimmer_channel_setpoint_control (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  dcsc_pkg::cmd_t                 in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output dcsc_pkg::result_t              out_data_o,
  input  wire                            cfg_we_i,
  input  wire [dcsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [dcsc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dcsc_pkg::*;

  cmd_t        cmd_q;
  logic        cmd_valid_q, cmd_valid_d;
  result_t     res_q, res_d;
  logic        res_valid_q, res_valid_d;
  chan_state_t state_q, state_d;
  cfg_t        cfg_q, cfg_d;
  logic        adv;

  assign adv        = cmd_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !cmd_valid_q || adv;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (in_ready_o) begin
      cmd_valid_d = in_valid_i;
    end
    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_LEVEL:  cfg_d.start_level        = cfg_data_i[6:0];
        CFG_DEFAULT_FADE: cfg_d.default_fade_rate  = cfg_data_i;
        CFG_INITIAL_LAST: cfg_d.initial_last_level = cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  dcsc_cmd u_cmd (
    .cmd_i    (cmd_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
      cfg_q       <= '{start_level: '0, default_fade_rate: '0,
                       initial_last_level: InitialLastReset};
    end else begin
      cmd_valid_q <= cmd_valid_d;
      res_valid_q <= res_valid_d;
      cfg_q       <= cfg_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// File: design/dcsc_checker.sv
// ----------------------------------------------------------------------------
// Dimmer channel setpoint control - port checker
// Checks handshake and status consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dimmer_channel_setpoint_control_assert.svh"

module dcsc_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input dcsc_pkg::result_t   out_data_o
);
  import dcsc_pkg::*;

  `DCSC_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out_valid dropped before transfer")
  `DCSC_ASSERT(a_out_data_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o), "stalled status changed")
  `DCSC_ASSERT(a_is_on, clk_i, rst_ni, out_valid_o |-> (out_data_o.is_on == (out_data_o.current_out != 8'd0)), "is_on disagrees with current level")
  `DCSC_ASSERT(a_is_changing, clk_i, rst_ni, out_valid_o |-> (out_data_o.is_changing == (out_data_o.current_out != {1'b0, out_data_o.setpoint_out})), "is_changing disagrees with levels")
  `DCSC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "status shown right after reset")

endmodule

bind dimmer_channel_setpoint_control dcsc_checker u_dcsc_checker (.*);

`default_nettype wire
